// File: sv/izn_pkg.sv
// ----------------------------------------------------------------------------
// izn_pkg
// Shared types, constants and fixed-point helpers for the neuron update block.
// ----------------------------------------------------------------------------
`default_nettype none
package izn_pkg;
    localparam int NEURONS_DEF  = 1024;
    localparam int SUBSTEPS_DEF = 4;
    localparam int IDX_W        = 10;
    localparam int CFG_AW       = 1;

    localparam logic signed [31:0] K_004 = 32'sd2621;
    localparam logic signed [31:0] K_5   = 32'sd327680;
    localparam logic signed [31:0] K_140 = 32'sd9175040;
    localparam logic signed [31:0] K_30  = 32'sd1966080;
    localparam logic [4:0] FRAC_RESET    = 5'd16;

    localparam logic MODE_STEP = 1'b0;
    localparam logic MODE_LOAD = 1'b1;

    typedef struct packed {
        logic                    mode;
        logic [IDX_W-1:0]        neuron;
        logic signed [31:0]      param_a;
        logic signed [31:0]      param_b;
        logic signed [31:0]      param_c;
        logic signed [31:0]      param_d;
        logic signed [31:0]      noise_scale;
        logic signed [31:0]      init_u;
        logic signed [31:0]      init_v;
        logic signed [31:0]      syn_current;
        logic signed [31:0]      noise_sample;
        logic                    force_fire;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]   neuron_out;
        logic               fired;
        logic signed [31:0] membrane_out;
        logic signed [31:0] recovery_out;
        logic [63:0]        history_out;
    } t_out_item;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        if (x > 66'sd2147483647) return 32'sh7fffffff;
        if (x < -66'sd2147483648) return 32'sh80000000;
        return x[31:0];
    endfunction

    // Q16.16 product, floor rounding (arithmetic shift), saturated
    function automatic logic signed [31:0] qmul(input logic signed [31:0] x,
                                               input logic signed [31:0] y);
        logic signed [63:0] p;
        p = x * y;
        return sat32(66'(p >>> 16));
    endfunction
endpackage
`default_nettype wire

// File: sv/izn_stream_if.sv
// ----------------------------------------------------------------------------
// izn_stream_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
`default_nettype none
interface izn_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: sv/izn_substep.sv
// ----------------------------------------------------------------------------
// izn_substep
// One pipelined Izhikevich sub-step: four register stages, one multiply each.
// ----------------------------------------------------------------------------
`default_nettype none
module izn_substep #(
    parameter int SUBSTEPS = izn_pkg::SUBSTEPS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic signed [31:0] i_v,
    input  wire logic signed [31:0] i_u,
    input  wire logic signed [31:0] i_a,
    input  wire logic signed [31:0] i_b,
    input  wire logic signed [31:0] i_cur,
    input  wire logic               i_fired,
    output logic signed [31:0]      o_v,
    output logic signed [31:0]      o_u,
    output logic                    o_fired
);
    import izn_pkg::*;

    localparam int SH = $clog2(SUBSTEPS);
    localparam bit POW2 = (SUBSTEPS & (SUBSTEPS - 1)) == 0;
    // ceil(2^34 / SUBSTEPS), exact for magnitudes below 2^31
    localparam logic [65:0] RECIP = ((66'd1 << 34) + 66'(SUBSTEPS - 1)) / 66'(SUBSTEPS);

    // floor division by the sub-step count; negative x via floor(x/d) = ~floor(~x/d)
    function automatic logic signed [31:0] fdiv(input logic signed [31:0] x);
        logic [31:0] m;
        logic [65:0] prod;
        logic [31:0] q;
        if (POW2) return x >>> SH;
        m    = x[31] ? ~x : x;
        prod = 66'(m) * RECIP;
        q    = prod[65:34];
        return x[31] ? ~q : q;
    endfunction

    logic signed [31:0] r_v1, r_u1, r_a1, r_b1, r_cur1, r_k1;
    logic               r_f1, r_f2, r_f3, r_f4;
    logic signed [31:0] r_v2, r_u2, r_a2, r_b2;
    logic signed [31:0] r_v3, r_u3, r_a3, r_bv3;
    logic signed [31:0] r_v4, r_u4, r_p4;
    logic signed [31:0] n_s, n_v;

    always_comb begin
        n_s = sat32(66'(qmul(r_k1, r_v1)) + 66'(K_140) - 66'(r_u1) + 66'(r_cur1));
        n_v = sat32(66'(r_v1) + 66'(fdiv(n_s)));
    end

    always_ff @(posedge i_clk) begin
        r_v1 <= i_v; r_u1 <= i_u; r_a1 <= i_a; r_b1 <= i_b; r_cur1 <= i_cur;
        r_f1 <= i_fired;
        r_k1 <= sat32(66'(qmul(K_004, i_v)) + 66'(K_5));
        r_f2 <= r_f1; r_u2 <= r_u1; r_a2 <= r_a1; r_b2 <= r_b1;
        r_v2 <= r_f1 ? r_v1 : n_v;
        r_f3 <= r_f2; r_u3 <= r_u2; r_a3 <= r_a2; r_v3 <= r_v2;
        r_bv3 <= sat32(66'(qmul(r_b2, r_v2)) - 66'(r_u2));
        r_f4 <= r_f3; r_u4 <= r_u3; r_v4 <= r_v3;
        r_p4 <= qmul(r_a3, r_bv3);
    end

    always_comb begin
        o_v     = r_v4;
        o_u     = r_f4 ? r_u4 : sat32(66'(r_u4) + 66'(fdiv(r_p4)));
        o_fired = r_f4 | (r_v4 >= K_30);
    end
endmodule
`default_nettype wire

// File: sv/izhikevich_neuron_update.sv
// Izhikevich neuron update. With distinct neurons and a ready sink an item is
// taken on every cycle, and its result passes in order through the neuron
// memory read, current scaling and the noise product, the sub-steps and the
// write into the result queue, made in the same cycle as the memory write-back.
// State sits in one synchronous memory; an item for a neuron still in flight
// is held at the input until that neuron's write-back is done. The result
// queue holds 4 + 4*SUBSTEPS transactions, enough for full rate; the input
// stalls once in-flight and queued results reach that count. The valid and
// history bits are cleared by a pass over all NEURONS entries after reset,
// during which no item is accepted.
// ----------------------------------------------------------------------------
// izhikevich_neuron_update
// Pipelined per-neuron Izhikevich update over a neuron table.
// ----------------------------------------------------------------------------
`default_nettype none
module izhikevich_neuron_update #(
    parameter int NEURONS  = izn_pkg::NEURONS_DEF,
    parameter int SUBSTEPS = izn_pkg::SUBSTEPS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    izn_stream_if.sink                       in_ch,
    izn_stream_if.source                     out_ch,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [izn_pkg::CFG_AW+1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import izn_pkg::*;

    localparam int AW    = (NEURONS > 1) ? $clog2(NEURONS) : 1;
    localparam int LAT   = 2 + 4 * SUBSTEPS;   // pipeline span from acceptance to write-back
    localparam int FIFO  = LAT + 2;            // covers the full round trip
    localparam int DEPTH = LAT;
    localparam int PW    = $clog2(FIFO);

    typedef struct packed {
        logic               valid;
        logic [63:0]        hist;
        logic signed [31:0] a, b, c, d, sigma, u, v;
    } t_entry;

    t_entry mem [NEURONS];

    // write-back port, driven by the final stage
    logic          wb_en;
    logic [AW-1:0] wb_idx;
    t_entry        wb_entry;
    logic          fin_v;

    // ---- configuration
    logic [4:0] r_frac;
    assign pready = 1'b1;
    assign prdata = (paddr[CFG_AW+1:2] == '0) ? {27'd0, r_frac} : 32'd0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frac <= FRAC_RESET;
        end else if (psel && penable && pwrite && paddr[CFG_AW+1:2] == '0) begin
            r_frac <= pwdata[4:0];
        end
    end

    // ---- clearing pass
    logic          r_clr;
    logic [AW:0]   r_clr_idx;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= 1'b1; r_clr_idx <= '0;
        end else if (r_clr) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == (AW+1)'(NEURONS - 1)) r_clr <= 1'b0;
        end
    end

    // ---- in-flight tracking: index and occupancy per stage
    logic              r_occ [DEPTH];
    logic [IDX_W-1:0]  r_idx [DEPTH];
    logic              hazard;
    always_comb begin
        hazard = 1'b0;
        for (int k = 0; k < DEPTH; k++)
            if (r_occ[k] && r_idx[k] == in_ch.data.neuron) hazard = 1'b1;
    end

    // output FIFO credit: items in flight plus held results
    logic [$clog2(DEPTH+FIFO+1)-1:0] r_cnt;
    logic accept, pop;
    assign in_ch.ready = !r_clr && !hazard && (r_cnt < ($bits(r_cnt))'(FIFO));
    assign accept = in_ch.valid && in_ch.ready;

    // ---- stage 0: read
    t_in_item r_it0;
    logic     r_ok0;   // index in range
    t_entry   r_rd;
    always_ff @(posedge i_clk) begin
        if (r_clr) begin
            mem[r_clr_idx[AW-1:0]].valid <= 1'b0;
            mem[r_clr_idx[AW-1:0]].hist  <= '0;
        end else if (wb_en) begin
            mem[wb_idx] <= wb_entry;
        end
        r_rd  <= mem[AW'(in_ch.data.neuron)];
        r_it0 <= in_ch.data;
        r_ok0 <= 32'(in_ch.data.neuron) < NEURONS;
    end

    // ---- stage 1: current scaling and noise product
    logic signed [31:0] n_cur;
    always_comb begin
        if (r_frac <= 5'd16)
            n_cur = sat32(66'(r_it0.syn_current) <<< (5'd16 - r_frac));
        else
            n_cur = 32'(r_it0.syn_current >>> (r_frac - 5'd16));
    end
    t_in_item r_it1; logic r_ok1; t_entry r_e1;
    logic signed [31:0] r_cur1, r_nz1;
    always_ff @(posedge i_clk) begin
        r_it1 <= r_it0; r_ok1 <= r_ok0; r_e1 <= r_rd;
        r_cur1 <= n_cur;
        r_nz1  <= qmul(r_rd.sigma, r_it0.noise_sample);
    end
    logic signed [31:0] cur2;
    assign cur2 = (r_e1.sigma != 0) ? sat32(66'(r_cur1) + 66'(r_nz1)) : r_cur1;

    // side-band delay for item, entry and current alongside the sub-steps
    t_in_item           r_itd  [4*SUBSTEPS];
    t_entry             r_ed   [4*SUBSTEPS];
    logic               r_okd  [4*SUBSTEPS];
    logic signed [31:0] r_curd [4*SUBSTEPS];
    always_ff @(posedge i_clk) begin
        r_itd[0] <= r_it1; r_ed[0] <= r_e1; r_okd[0] <= r_ok1; r_curd[0] <= cur2;
        for (int k = 1; k < 4*SUBSTEPS; k++) begin
            r_itd[k] <= r_itd[k-1]; r_ed[k] <= r_ed[k-1]; r_okd[k] <= r_okd[k-1];
            r_curd[k] <= r_curd[k-1];
        end
    end

    // ---- sub-step chain; a, b and current follow their item down the delay line
    logic signed [31:0] sv [SUBSTEPS+1];
    logic signed [31:0] su [SUBSTEPS+1];
    logic               sf [SUBSTEPS+1];
    logic signed [31:0] sa [SUBSTEPS];
    logic signed [31:0] sb [SUBSTEPS];
    logic signed [31:0] sc [SUBSTEPS];
    assign sv[0] = r_e1.v;
    assign su[0] = r_e1.u;
    assign sf[0] = 1'b0;
    for (genvar g = 0; g < SUBSTEPS; g++) begin : g_sub
        if (g == 0) begin : g_head
            assign sa[g] = r_e1.a;
            assign sb[g] = r_e1.b;
            assign sc[g] = cur2;
        end else begin : g_tail
            assign sa[g] = r_ed[4*g-1].a;
            assign sb[g] = r_ed[4*g-1].b;
            assign sc[g] = r_curd[4*g-1];
        end
        izn_substep #(.SUBSTEPS(SUBSTEPS)) u_sub (
            .i_clk(i_clk), .i_v(sv[g]), .i_u(su[g]), .i_a(sa[g]), .i_b(sb[g]),
            .i_cur(sc[g]), .i_fired(sf[g]),
            .o_v(sv[g+1]), .o_u(su[g+1]), .o_fired(sf[g+1]));
    end

    // ---- final stage: firing, history, write-back
    t_in_item fit; t_entry fe; logic fok;
    assign fit = r_itd[4*SUBSTEPS-1];
    assign fe  = r_ed[4*SUBSTEPS-1];
    assign fok = r_okd[4*SUBSTEPS-1];

    t_out_item   res;
    logic        fire;
    always_comb begin
        fire     = sf[SUBSTEPS] | fit.force_fire;
        wb_entry = fe;
        wb_idx   = AW'(fit.neuron);
        res      = '0;
        res.neuron_out = fit.neuron;
        wb_en    = 1'b0;
        if (fin_v && fok && fit.mode == MODE_LOAD) begin
            wb_en = 1'b1;
            wb_entry.valid = 1'b1;
            wb_entry.a = fit.param_a; wb_entry.b = fit.param_b;
            wb_entry.c = fit.param_c; wb_entry.d = fit.param_d;
            wb_entry.sigma = fit.noise_scale;
            wb_entry.u = fit.init_u; wb_entry.v = fit.init_v;
            res.membrane_out = fit.init_v;
            res.recovery_out = fit.init_u;
            res.history_out  = fe.hist;
        end else if (fin_v && fok && fe.valid) begin
            wb_en = 1'b1;
            wb_entry.hist = {fe.hist[62:0], fire};
            wb_entry.v = fire ? fe.c : sv[SUBSTEPS];
            wb_entry.u = fire ? sat32(66'(su[SUBSTEPS]) + 66'(fe.d)) : su[SUBSTEPS];
            res.fired = fire;
            res.membrane_out = wb_entry.v;
            res.recovery_out = wb_entry.u;
            res.history_out  = wb_entry.hist;
        end
    end

    // occupancy pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) r_occ[k] <= 1'b0;
        end else begin
            r_occ[0] <= accept;
            for (int k = 1; k < DEPTH; k++) r_occ[k] <= r_occ[k-1];
        end
        r_idx[0] <= in_ch.data.neuron;
        for (int k = 1; k < DEPTH; k++) r_idx[k] <= r_idx[k-1];
    end
    assign fin_v = r_occ[LAT-1];

    // ---- output FIFO
    t_out_item r_q [FIFO];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_qn;
    assign pop = out_ch.valid && out_ch.ready;
    assign out_ch.valid = r_qn != '0;
    assign out_ch.data  = r_q[r_rp];
    always_ff @(posedge i_clk) begin
        if (fin_v) r_q[r_wp] <= res;
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_qn <= '0; r_cnt <= '0;
        end else begin
            if (fin_v) r_wp <= (r_wp == PW'(FIFO - 1)) ? '0 : r_wp + 1'b1;
            if (pop)   r_rp <= (r_rp == PW'(FIFO - 1)) ? '0 : r_rp + 1'b1;
            r_qn  <= r_qn + ($bits(r_qn))'(fin_v) - ($bits(r_qn))'(pop);
            r_cnt <= r_cnt + ($bits(r_cnt))'(accept) - ($bits(r_cnt))'(pop);
        end
    end
endmodule
`default_nettype wire

// File: sv/izn_checker.sv
// ----------------------------------------------------------------------------
// izn_checker
// Port-level checks on the neuron update block.
// ----------------------------------------------------------------------------
`default_nettype none
module izn_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic pready
);
    a_pready: assert property (@(posedge i_clk) pready) else $error("pready low");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !out_valid)
        else $error("result after reset");
    a_clr: assert property (@(posedge i_clk) !i_rst_n |=> !in_ready)
        else $error("input taken during clear");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
endmodule
bind izhikevich_neuron_update izn_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .pready(pready));
`default_nettype wire

// File: verif/izhikevich_neuron_update_tb.sv
// ----------------------------------------------------------------------------
// izhikevich_neuron_update_tb
// Self-checking bench: loads and steps neurons over valid/ready channels,
// predicts each result in Q16.16 and compares it with the received item as a whole.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module izhikevich_neuron_update_tb;
    import izn_pkg::*;

    localparam int  NUM_NEURONS = 1024;
    localparam int  SUBSTEPS    = 4;
    localparam int  LATENCY     = 2 + 4 * SUBSTEPS;
    localparam logic [CFG_AW+1:0] ADDR_FRAC = 'd0;
    localparam longint CYCLE_LIMIT = 2000000;
    localparam int  MAX_SHOWN   = 10;
    localparam int  POOL        = 24;   // neurons used by most items, to hit clashes

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [CFG_AW+1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    izn_stream_if #(.T(t_in_item))  in_ch ();
    izn_stream_if #(.T(t_out_item)) out_ch ();

    izhikevich_neuron_update u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 i_clk = ~i_clk;

    // predictor state
    logic signed [31:0] mdl_a [NUM_NEURONS];
    logic signed [31:0] mdl_b [NUM_NEURONS];
    logic signed [31:0] mdl_c [NUM_NEURONS];
    logic signed [31:0] mdl_d [NUM_NEURONS];
    logic signed [31:0] mdl_sigma [NUM_NEURONS];
    logic signed [31:0] mdl_v [NUM_NEURONS];
    logic signed [31:0] mdl_u [NUM_NEURONS];
    logic               mdl_loaded [NUM_NEURONS];
    logic [63:0]        mdl_hist [NUM_NEURONS];
    logic [4:0]         mdl_frac;

    t_out_item expected_updates [$];
    int  mismatches = 0;
    int  results_seen = 0;
    int  fires_seen = 0;
    int  items_sent = 0;
    longint cycles = 0;
    bit  hold_off = 1'b0;
    int  stall_pct = 30;

    function automatic longint clip32(input longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // floor shift: >>> on signed longint floors
    function automatic longint fx_mul(input longint x, input longint y);
        longint p;
        p = x * y;
        return clip32(p >>> 16);
    endfunction

    function automatic longint floor_quarter(input longint x);
        return x >>> 2;   // SUBSTEPS is 4: floor division is an arithmetic shift
    endfunction

    function automatic t_out_item predict_update(input t_in_item it);
        t_out_item r;
        int n;
        longint cur, v, u, k, s, p;
        bit fire;
        r = '0;
        r.neuron_out = it.neuron;
        n = it.neuron;
        if (it.mode == MODE_LOAD) begin
            mdl_a[n] = it.param_a; mdl_b[n] = it.param_b;
            mdl_c[n] = it.param_c; mdl_d[n] = it.param_d;
            mdl_sigma[n] = it.noise_scale;
            mdl_u[n] = it.init_u; mdl_v[n] = it.init_v;
            mdl_loaded[n] = 1'b1;
            r.membrane_out = it.init_v;
            r.recovery_out = it.init_u;
            r.history_out = mdl_hist[n];
            return r;
        end
        if (!mdl_loaded[n]) return r;
        cur = longint'(it.syn_current);
        if (mdl_frac <= 16) cur = clip32(cur * (64'sd1 << (16 - mdl_frac)));
        else cur = cur >>> (mdl_frac - 16);
        if (mdl_sigma[n] != 0)
            cur = clip32(cur + fx_mul(mdl_sigma[n], it.noise_sample));
        v = mdl_v[n];
        u = mdl_u[n];
        fire = 1'b0;
        for (int t = 0; t < SUBSTEPS; t++) begin
            if (!fire) begin
                k = clip32(fx_mul(K_004, v) + K_5);
                s = clip32(fx_mul(k, v) + K_140 - u + cur);
                v = clip32(v + floor_quarter(s));
                p = fx_mul(mdl_a[n], clip32(fx_mul(mdl_b[n], v) - u));
                u = clip32(u + floor_quarter(p));
                fire = v >= K_30;
            end
        end
        fire |= it.force_fire;
        mdl_hist[n] = {mdl_hist[n][62:0], fire};
        if (fire) begin
            v = mdl_c[n];
            u = clip32(u + mdl_d[n]);
        end
        mdl_v[n] = v[31:0];
        mdl_u[n] = u[31:0];
        r.fired = fire;
        r.membrane_out = v[31:0];
        r.recovery_out = u[31:0];
        r.history_out = mdl_hist[n];
        return r;
    endfunction

    // result checker and receiver stalls
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        if (out_ch.valid && out_ch.ready) begin
            t_out_item e;
            results_seen <= results_seen + 1;
            if (expected_updates.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < MAX_SHOWN)
                    $display("unexpected result for neuron %0d", out_ch.data.neuron_out);
            end else begin
                e = expected_updates.pop_front();
                if (e.fired) fires_seen <= fires_seen + 1;
                if (out_ch.data !== e) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < MAX_SHOWN)
                        $display("mismatch exp n=%0d f=%0b v=%h u=%h h=%h got n=%0d f=%0b v=%h u=%h h=%h",
                                 e.neuron_out, e.fired, e.membrane_out, e.recovery_out,
                                 e.history_out, out_ch.data.neuron_out, out_ch.data.fired,
                                 out_ch.data.membrane_out, out_ch.data.recovery_out,
                                 out_ch.data.history_out);
                end
            end
        end
    end

    always @(negedge i_clk)
        out_ch.ready <= !i_rst_n ? 1'b0 :
                        hold_off ? 1'b0 : ($urandom_range(99) >= stall_pct);

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        for (int i = 0; i < NUM_NEURONS; i++) begin
            mdl_loaded[i] = 1'b0;
            mdl_hist[i] = '0;
        end
        mdl_frac = FRAC_RESET;
    end

    // one transaction on the input channel, entered and left at a falling edge;
    // prediction made at acceptance, back-to-back calls keep valid high
    task automatic send_item(input t_in_item it);
        in_ch.data = it;
        in_ch.valid = 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        expected_updates.insert(expected_updates.size(), predict_update(it));
        items_sent++;
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic random_gap();
        if ($urandom_range(7) == 0)
            repeat ($urandom_range(6, 1)) @(negedge i_clk);
    endtask

    task automatic drain();
        while (expected_updates.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_frac(input logic [4:0] value);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_FRAC; pwdata <= {27'd0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        mdl_frac = value;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $urandom;
            default: return $signed($urandom_range(40 << 16)) - (20 << 16);
        endcase
    endfunction

    function automatic t_in_item make_load(input int n);
        t_in_item it;
        it = '0;
        it.mode = MODE_LOAD;
        it.neuron = IDX_W'(n);
        // mostly biologically plausible values so spiking really happens
        if ($urandom_range(4) != 0) begin
            it.param_a = 1311 + $urandom_range(5000);
            it.param_b = 13107 + $urandom_range(4000);
            it.param_c = -(65 << 16) + $urandom_range(15 << 16);
            it.param_d = $urandom_range(8 << 16);
            it.noise_scale = $urandom_range(1) ? 0 : $urandom_range(3 << 16);
            it.init_v = -(70 << 16) + $urandom_range(40 << 16);
            it.init_u = -(14 << 16) + $urandom_range(4 << 16);
        end else begin
            it.param_a = rand_word(); it.param_b = rand_word();
            it.param_c = rand_word(); it.param_d = rand_word();
            it.noise_scale = rand_word(); it.init_v = rand_word(); it.init_u = rand_word();
        end
        it.syn_current = $urandom; it.noise_sample = $urandom;
        it.force_fire = 1'($urandom);
        return it;
    endfunction

    function automatic t_in_item make_step(input int n);
        t_in_item it;
        it = '0;
        it.mode = MODE_STEP;
        it.neuron = IDX_W'(n);
        it.syn_current = $urandom_range(3) == 0 ? $urandom
                         : $signed(32'($urandom_range(20 << mdl_frac)));
        it.noise_sample = $urandom_range(3) == 0 ? $urandom
                          : $signed($urandom_range(4 << 16)) - (2 << 16);
        it.force_fire = ($urandom_range(9) == 0);
        it.param_a = $urandom; it.param_b = $urandom; it.param_c = $urandom;
        it.param_d = $urandom; it.noise_scale = $urandom;
        it.init_u = $urandom; it.init_v = $urandom;
        return it;
    endfunction

    task automatic test_directed();
        t_in_item it;
        // stepping neurons never loaded, including the top index
        send_item(make_step(0));
        send_item(make_step(NUM_NEURONS - 1));
        it = make_load(0);
        it.param_a = 1311; it.param_b = 13107; it.param_c = -(65 << 16);
        it.param_d = 8 << 16; it.noise_scale = 0; it.init_v = -(65 << 16); it.init_u = 0;
        send_item(it);
        it = make_step(0); it.syn_current = 10 << 16; it.force_fire = 1'b0;
        repeat (6) send_item(it);
        it.force_fire = 1'b1; send_item(it);
        // saturating extremes
        it = make_load(NUM_NEURONS - 1);
        it.param_a = 32'sh7fffffff; it.param_b = 32'sh80000000; it.param_c = 32'sh7fffffff;
        it.param_d = 32'sh7fffffff; it.noise_scale = 32'sh7fffffff;
        it.init_v = 32'sh7fffffff; it.init_u = 32'sh80000000;
        send_item(it);
        it = make_step(NUM_NEURONS - 1);
        it.syn_current = 32'sh7fffffff; it.noise_sample = 32'sh7fffffff; send_item(it);
        it.syn_current = 32'sh80000000; it.noise_sample = 32'sh80000000; send_item(it);
        it = make_load(1);
        it.param_a = 32'sh80000000; it.param_b = 32'sh7fffffff; it.param_c = 32'sh80000000;
        it.param_d = 32'sh80000000; it.noise_scale = 32'sh80000000;
        it.init_v = 32'sh80000000; it.init_u = 32'sh7fffffff;
        send_item(it);
        it = make_step(1); it.syn_current = 32'sh80000000; send_item(it);
        it.syn_current = 32'sh7fffffff; it.force_fire = 1'b1; send_item(it);
        // reload keeps history
        send_item(make_load(0));
        drain();
    endtask

    task automatic test_random(input int count, input int gap_mode);
        int n;
        for (int i = 0; i < count; i++) begin
            n = $urandom_range(7) == 0 ? $urandom_range(NUM_NEURONS - 1)
                                       : $urandom_range(POOL - 1);
            if (!mdl_loaded[n] || $urandom_range(15) == 0) send_item(make_load(n));
            else send_item(make_step(n));
            if (gap_mode) random_gap();
        end
    endtask

    task automatic test_frac_settings();
        logic [4:0] settings [5] = '{5'd0, 5'd31, 5'd8, 5'd20, FRAC_RESET};
        foreach (settings[i]) begin
            write_frac(settings[i]);
            test_random(120, i % 2);
            drain();
        end
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (200) @(posedge i_clk);
                hold_off = 1'b0;
            end
            test_random(80, 0);
        join
        drain();
    endtask

    task automatic test_no_stall();
        stall_pct = 0;
        test_random(120, 0);
        stall_pct = 30;
        drain();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_frac_settings();
        test_backpressure();
        test_no_stall();
        stall_pct = 60;
        test_random(200, 1);
        drain();
        $display("Covered %0d items, %0d results, %0d firings, several frac settings and stalls.",
                 items_sent, results_seen, fires_seen);
        if (mismatches == 0 && expected_updates.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire

// File: filelist.f
sv/izn_pkg.sv
sv/izn_stream_if.sv
sv/izn_substep.sv
sv/izhikevich_neuron_update.sv
sv/izn_checker.sv
verif/izhikevich_neuron_update_tb.sv
